@@ rtl/core/wdq_pkg.sv @@
package wdq_pkg;

    // field and datapath widths
    localparam int HourW     = 5;
    localparam int MinuteW   = 6;
    localparam int SecondW   = 6;
    localparam int IntervalW = 17;
    localparam int QuietMinW = 11;
    localparam int DelayW    = 18;
    localparam int TimeW     = 17;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 17;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 24;

    // time constants
    localparam logic [TimeW-1:0] SecPerHour = TimeW'(3600);
    localparam logic [TimeW-1:0] SecPerMin  = TimeW'(60);
    localparam int               SecPerDay  = 86400;
    localparam int               MinDelay   = 60;
    localparam int               OutMax     = 262143;

    // register reset values
    localparam logic [IntervalW-1:0] IntervalReset   = IntervalW'(3600);
    localparam logic [QuietMinW-1:0] QuietStartReset = QuietMinW'(1380);
    localparam logic [QuietMinW-1:0] QuietEndReset   = QuietMinW'(420);

    // register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_INTERVAL    = 3'd0,
        REG_ALIGN       = 3'd1,
        REG_QUIET_EN    = 3'd2,
        REG_QUIET_START = 3'd3,
        REG_QUIET_END   = 3'd4
    } cfg_reg_t;

endpackage

@@ rtl/core/wakeup_delay_with_quiet_window.sv @@
// Wake-up delay calculator. Each beat on s_ carries a time of day and returns the
// seconds until the next wake-up on m_. One beat is taken every cycle unless m_tready
// stalls the output. A 17-stage remainder pipeline (one restoring step per stage)
// finds the position of the time, and of the quiet window end, on the
// interval grid. The block keeps no state between beats. Configuration writes are
// taken at any time with cfg_ready high, but must only be issued while no beat is in
// flight.
module wakeup_delay_with_quiet_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // hour_of_day [4:0], minute_of_hour [10:5], second_of_minute [16:11], zeros above
    input  logic [wdq_pkg::InDataW-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // wake_delay_seconds [17:0], zeros above
    output logic [wdq_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wdq_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [wdq_pkg::CfgDataW-1:0]  cfg_data
);
    import wdq_pkg::*;

    localparam int Last = TimeW + 2;

    logic [IntervalW-1:0] interval_reg;
    logic                 align_reg;
    logic                 quiet_en_reg;
    logic [QuietMinW-1:0] quiet_start_reg;
    logic [QuietMinW-1:0] quiet_end_reg;
    logic [Last:0]        valid_reg;
    logic                 en;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg    <= IntervalReset;
            align_reg       <= 1'b0;
            quiet_en_reg    <= 1'b0;
            quiet_start_reg <= QuietStartReset;
            quiet_end_reg   <= QuietEndReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INTERVAL:    interval_reg    <= cfg_data[IntervalW-1:0];
                REG_ALIGN:       align_reg       <= cfg_data[0];
                REG_QUIET_EN:    quiet_en_reg    <= cfg_data[0];
                REG_QUIET_START: quiet_start_reg <= cfg_data[QuietMinW-1:0];
                REG_QUIET_END:   quiet_end_reg   <= cfg_data[QuietMinW-1:0];
                default: ;
            endcase
        end
    end

    // derived configuration values
    logic [TimeW-1:0] iv;
    logic [TimeW-1:0] qs_sec;
    logic [TimeW-1:0] qe_sec;
    assign iv     = (interval_reg == '0) ? TimeW'(1) : interval_reg;
    assign qs_sec = TimeW'({6'b0, quiet_start_reg} * SecPerMin);
    assign qe_sec = TimeW'({6'b0, quiet_end_reg} * SecPerMin);

    // global stall: everything moves when the output slot is free or taken
    assign en       = !valid_reg[Last] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[Last];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[Last-1:0], s_tvalid};
        end
    end

    // stage 0: seconds since midnight
    logic [TimeW-1:0] now_next;
    logic [TimeW-1:0] now_reg;
    logic [TimeW-1:0] qe0_reg;
    assign now_next = TimeW'(s_tdata[HourW-1:0]) * SecPerHour
                    + TimeW'(s_tdata[HourW+MinuteW-1:HourW]) * SecPerMin
                    + TimeW'(s_tdata[HourW+MinuteW+SecondW-1:HourW+MinuteW]);
    always_ff @(posedge aclk) begin
        if (en) begin
            now_reg <= now_next;
            qe0_reg <= qe_sec;
        end
    end

    // remainder lanes: time of day and window end against the interval
    logic [TimeW-1:0] now_d;
    logic [TimeW-1:0] rem_now;
    logic [TimeW-1:0] qe_d;
    logic [TimeW-1:0] rem_qe;

    wdq_rem_pipe #(.W(TimeW)) u_now_rem (
        .aclk    (aclk),
        .en      (en),
        .num_in  (now_reg),
        .dvs     (iv),
        .num_out (now_d),
        .rem_out (rem_now)
    );

    wdq_rem_pipe #(.W(TimeW)) u_qe_rem (
        .aclk    (aclk),
        .en      (en),
        .num_in  (qe0_reg),
        .dvs     (iv),
        .num_out (qe_d),
        .rem_out (rem_qe)
    );

    // stage a: tentative delay and window end, aligned to the grid when align_reg is set
    logic [TimeW-1:0]  to_slot;
    logic [DelayW-1:0] delay_next;
    logic [DelayW-1:0] target_next;
    logic [DelayW-1:0] delay_reg;
    logic [DelayW-1:0] target_reg;
    logic [TimeW-1:0]  now_a_reg;

    always_comb begin
        to_slot = iv - rem_now;
        if (align_reg) begin
            if (to_slot < TimeW'(MinDelay)) begin
                delay_next = DelayW'(to_slot) + DelayW'(iv);
            end else begin
                delay_next = DelayW'(to_slot);
            end
            target_next = DelayW'(qe_d - rem_qe)
                        + ((rem_qe != '0) ? DelayW'(iv) : '0);
        end else begin
            delay_next  = DelayW'(iv);
            target_next = DelayW'(qe_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delay_reg  <= delay_next;
            target_reg <= target_next;
            now_a_reg  <= now_d;
        end
    end

    // stage b: quiet window check and final delay
    logic [18:0]        wake0;
    logic [18:0]        wake1;
    logic [18:0]        wake;
    logic               in_quiet;
    logic signed [20:0] diff;
    logic signed [20:0] dq;
    logic [DelayW-1:0]  result_next;
    logic [DelayW-1:0]  result_reg;

    always_comb begin
        wake0 = 19'(now_a_reg) + 19'(delay_reg);
        wake1 = (wake0 >= 19'(SecPerDay)) ? wake0 - 19'(SecPerDay) : wake0;
        wake  = (wake1 >= 19'(SecPerDay)) ? wake1 - 19'(SecPerDay) : wake1;

        if (qs_sec > qe_sec) begin
            in_quiet = (wake >= 19'(qs_sec)) || (wake < 19'(qe_sec));
        end else begin
            in_quiet = (wake >= 19'(qs_sec)) && (wake < 19'(qe_sec));
        end

        diff = $signed({3'b0, target_reg}) - $signed({4'b0, now_a_reg});
        if (qs_sec > qe_sec) begin
            if (now_a_reg < qe_sec && now_a_reg < qs_sec) begin
                dq = diff;
            end else begin
                dq = diff + 21'sd86400;
            end
        end else if (diff < 0) begin
            dq = diff + 21'sd86400;
        end else begin
            dq = diff;
        end

        if (!quiet_en_reg || !in_quiet) begin
            result_next = delay_reg;
        end else if (dq < 0) begin
            result_next = '0;
        end else if (dq > 21'(OutMax)) begin
            result_next = DelayW'(OutMax);
        end else begin
            result_next = dq[DelayW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = {(OutDataW - DelayW)'(0), result_reg};
endmodule

@@ rtl/core/wdq_rem_pipe.sv @@
module wdq_rem_pipe #(
    parameter int W = wdq_pkg::TimeW
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] num_in,
    input  logic [W-1:0] dvs,
    output logic [W-1:0] num_out,
    output logic [W-1:0] rem_out
);
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] num_reg [W];

    // one restoring step per stage, msb of the dividend first
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] rem_prev;
        logic [W-1:0] num_prev;
        logic [W:0]   trial;
        logic [W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = num_in;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
        end

        always_comb begin
            trial = {rem_prev, num_prev[W-1-k]};
            if (trial >= {1'b0, dvs}) begin
                rem_next = W'(trial - {1'b0, dvs});
            end else begin
                rem_next = trial[W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_prev;
            end
        end
    end

    assign num_out = num_reg[W-1];
    assign rem_out = rem_reg[W-1];
endmodule
